>>> design/ttsd_pkg.sv
// shared constants and the arctangent table for the tilt to servo duty block
package ttsd_pkg;

    // default duty range and rotation step count
    localparam int DUTY_MIN_DEF     = 1638;
    localparam int DUTY_MAX_DEF     = 8192;
    localparam int CORDIC_STEPS_DEF = 16;

    // length of the arctangent table
    localparam int ATAN_LEN = 24;

    // ninety degrees in 1/65536 degree units
    localparam logic signed [24:0] DEG90 = 25'sd5898240;

    // register map, word index
    localparam logic [2:0] REG_ALPHA   = 3'd0;
    localparam logic [2:0] REG_H_MIN   = 3'd1;
    localparam logic [2:0] REG_H_MAX   = 3'd2;
    localparam logic [2:0] REG_V_MIN   = 3'd3;
    localparam logic [2:0] REG_V_MAX   = 3'd4;
    localparam logic [2:0] REG_POT_LO  = 3'd5;
    localparam logic [2:0] REG_POT_HI  = 3'd6;
    localparam logic [2:0] REG_INVERT  = 3'd7;

    // atan(2^-i) in 1/65536 degree, rounded
    function automatic logic [21:0] atan_q16(input logic [4:0] idx);
        logic [21:0] r;
        case (idx)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/tilt_to_servo_duty_core.sv
// top level: register port, item capture, tilt and duty units, output register
// Each item takes one accelerometer triple and a potentiometer sample and yields
// three servo duties. The next item is taken only after the result has been loaded
// into the output register. The tilt phase runs the squaring of both side inputs,
// the bit-serial square root, the rotation loop at one step a cycle, the angle
// select, the serial filter multiply, a finish step and the done handoff. The duty
// phase runs the offset multiply, divider set-up, the serial divide, a finish step
// and the done handoff. The result is then loaded into the output register from the
// push step once that register is free. Pitch and roll run side by side in two tilt
// units, the three duties in three duty units. One item is worked on at a time; a
// result still waiting in the output register holds the block in the push step, and
// the input stays stalled until it is taken.
module tilt_to_servo_duty_core
    import ttsd_pkg::*;
#(
    parameter int DUTY_MIN     = DUTY_MIN_DEF,
    parameter int DUTY_MAX     = DUTY_MAX_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // accel_x, accel_y, accel_z, pot_sample, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // duty_shoulder_h, duty_shoulder_v, duty_elbow, pad
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ANGLE = 2'd1;
    localparam logic [1:0] ST_DUTY  = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [15:0]        alpha_reg;
    logic signed [15:0] h_min_reg, h_max_reg, v_min_reg, v_max_reg;
    logic [11:0]        pot_lo_reg, pot_hi_reg;
    logic [2:0]         inv_reg;

    logic [1:0]         state_reg, state_next;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [11:0]        pot_reg;
    logic               mval_reg, mval_next;
    logic [47:0]        mdata_reg, mdata_next;

    logic               cfg_wr, in_acc, out_free;
    logic               pitch_done, roll_done, h_done, v_done, e_done;
    logic signed [23:0] pitch_f, roll_f;
    logic [13:0]        duty_h, duty_v, duty_e;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !mval_reg || m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= 16'd49152;
            h_min_reg  <= -16'sd15360;
            h_max_reg  <= 16'sd15360;
            v_min_reg  <= -16'sd15360;
            v_max_reg  <= 16'sd15360;
            pot_lo_reg <= 12'd600;
            pot_hi_reg <= 12'd4095;
            inv_reg    <= 3'd0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ALPHA:  alpha_reg  <= pwdata[15:0];
                REG_H_MIN:  h_min_reg  <= signed'(pwdata[15:0]);
                REG_H_MAX:  h_max_reg  <= signed'(pwdata[15:0]);
                REG_V_MIN:  v_min_reg  <= signed'(pwdata[15:0]);
                REG_V_MAX:  v_max_reg  <= signed'(pwdata[15:0]);
                REG_POT_LO: pot_lo_reg <= pwdata[11:0];
                REG_POT_HI: pot_hi_reg <= pwdata[11:0];
                REG_INVERT: inv_reg    <= pwdata[2:0];
                default:    inv_reg    <= inv_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[4:2])
            REG_ALPHA:  prdata = {16'd0, alpha_reg};
            REG_H_MIN:  prdata = {16'd0, h_min_reg};
            REG_H_MAX:  prdata = {16'd0, h_max_reg};
            REG_V_MIN:  prdata = {16'd0, v_min_reg};
            REG_V_MAX:  prdata = {16'd0, v_max_reg};
            REG_POT_LO: prdata = {20'd0, pot_lo_reg};
            REG_POT_HI: prdata = {20'd0, pot_hi_reg};
            REG_INVERT: prdata = {29'd0, inv_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // item sequencing and output register
    always_comb
    begin
        state_next = state_reg;
        mval_next  = mval_reg && !m_tready;
        mdata_next = mdata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                if (pitch_done)
                    state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                if (h_done)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    mval_next  = 1'b1;
                    mdata_next = {6'd0, duty_e, duty_v, duty_h};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ax_reg  <= signed'(s_tdata[15:0]);
            ay_reg  <= signed'(s_tdata[31:16]);
            az_reg  <= signed'(s_tdata[47:32]);
            pot_reg <= s_tdata[59:48];
        end
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;

    // pitch from x against y and z, roll from y against x and z
    ttsd_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk(clk), .rst_n(rst_n), .start(in_acc),
        .num(ax_reg), .side_a(ay_reg), .side_b(az_reg), .alpha(alpha_reg),
        .done(pitch_done), .filtered(pitch_f)
    );

    ttsd_tilt #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk(clk), .rst_n(rst_n), .start(in_acc),
        .num(ay_reg), .side_a(ax_reg), .side_b(az_reg), .alpha(alpha_reg),
        .done(roll_done), .filtered(roll_f)
    );

    // duty mapping, tilt limits scaled to 1/65536 degree, pot limits used as they are
    ttsd_duty #(.DUTY_MIN(DUTY_MIN), .DUTY_MAX(DUTY_MAX)) u_duty_h (
        .clk(clk), .rst_n(rst_n), .start(pitch_done),
        .value(25'(roll_f)), .lo({h_min_reg[15], h_min_reg, 8'd0}),
        .hi({h_max_reg[15], h_max_reg, 8'd0}),
        .mirror(inv_reg[0]), .done(h_done), .duty(duty_h)
    );

    ttsd_duty #(.DUTY_MIN(DUTY_MIN), .DUTY_MAX(DUTY_MAX)) u_duty_v (
        .clk(clk), .rst_n(rst_n), .start(pitch_done),
        .value(25'(pitch_f)), .lo({v_min_reg[15], v_min_reg, 8'd0}),
        .hi({v_max_reg[15], v_max_reg, 8'd0}),
        .mirror(inv_reg[1]), .done(v_done), .duty(duty_v)
    );

    ttsd_duty #(.DUTY_MIN(DUTY_MIN), .DUTY_MAX(DUTY_MAX)) u_duty_e (
        .clk(clk), .rst_n(rst_n), .start(pitch_done),
        .value(signed'({13'd0, pot_reg})), .lo(signed'({13'd0, pot_lo_reg})),
        .hi(signed'({13'd0, pot_hi_reg})),
        .mirror(inv_reg[2]), .done(e_done), .duty(duty_e)
    );

    // both tilt units run in lockstep
    a_tilt_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        pitch_done == roll_done)
        else $error("tilt units out of step");

    // the three duty units finish together
    a_duty_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (h_done == v_done) && (h_done == e_done))
        else $error("duty units out of step");

    // an accepted item starts the angle phase
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_ANGLE)
        else $error("item accepted without starting");

    // a result is only loaded from the push state
    a_load_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_PUSH)
        else $error("result loaded outside push");

endmodule

>>> design/ttsd_tilt.sv
// one tilt axis: bit-serial square root, iterative cordic arctangent, serial filter
module ttsd_tilt
    import ttsd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] num,
    input  logic signed [15:0] side_a,
    input  logic signed [15:0] side_b,
    input  logic [15:0]        alpha,
    output logic               done,
    output logic signed [23:0] filtered
);

    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [4:0] ROT_LAST  = 5'(NSTEP - 1);
    localparam logic [4:0] ROOT_LAST = 5'd23;
    localparam logic [4:0] FILT_LAST = 5'd15;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQA  = 3'd1;
    localparam logic [2:0] S_SQB  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_ROT  = 3'd4;
    localparam logic [2:0] S_ANG  = 3'd5;
    localparam logic [2:0] S_FILT = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [31:0]         sum_reg, sum_next;
    logic [47:0]         rad_reg, rad_next;
    logic [26:0]         rem_reg, rem_next;
    logic [23:0]         root_reg, root_next;
    logic signed [26:0]  x_reg, x_next, y_reg, y_next;
    logic signed [24:0]  z_reg, z_next;
    logic                zero_reg, zero_next;
    logic signed [24:0]  ang_reg, ang_next, diff_reg, diff_next;
    logic signed [41:0]  acc_reg, acc_next;
    logic [15:0]         ash_reg, ash_next;
    logic signed [23:0]  filt_reg, filt_next;

    logic signed [15:0]  sq_op;
    logic signed [31:0]  sq;
    logic [31:0]         sum_all;
    logic [26:0]         remsh, trial;
    logic signed [26:0]  dx, dy;
    logic signed [24:0]  atan_v, ang_sel;
    logic signed [41:0]  addend, rnd;
    logic signed [25:0]  newf;

    // shared squarer, root step, rotation shifts, angle select and filter terms
    always_comb
    begin
        sq_op   = (state_reg == S_SQA) ? side_a : side_b;
        sq      = sq_op * sq_op;
        sum_all = sum_reg + 32'(unsigned'(sq));
        remsh   = {rem_reg[24:0], rad_reg[47:46]};
        trial   = {1'b0, root_reg, 2'b01};
        dx      = y_reg >>> cnt_reg;
        dy      = x_reg >>> cnt_reg;
        atan_v  = signed'({3'b000, atan_q16(cnt_reg)});
        if (!zero_reg)
            ang_sel = z_reg;
        else if (num > 16'sd0)
            ang_sel = DEG90;
        else if (num < 16'sd0)
            ang_sel = -DEG90;
        else
            ang_sel = 25'sd0;
        addend  = ash_reg[15] ? 42'(diff_reg) : 42'sd0;
        rnd     = (acc_reg + 42'sd32768) >>> 16;
        newf    = 26'(ang_reg) + rnd[25:0];
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        sum_next   = sum_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        ang_next   = ang_reg;
        diff_next  = diff_reg;
        acc_next   = acc_reg;
        ash_next   = ash_reg;
        filt_next  = filt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_SQA;
            end
            S_SQA:
            begin
                sum_next   = 32'(unsigned'(sq));
                zero_next  = (side_a == 16'sd0) && (side_b == 16'sd0);
                state_next = S_SQB;
            end
            S_SQB:
            begin
                rad_next   = {sum_all, 16'd0};
                rem_next   = 27'd0;
                root_next  = 24'd0;
                cnt_next   = 5'd0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                rad_next = {rad_reg[45:0], 2'b00};
                if (remsh >= trial)
                begin
                    rem_next  = remsh - trial;
                    root_next = {root_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next  = remsh;
                    root_next = {root_reg[22:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == ROOT_LAST)
                begin
                    cnt_next   = 5'd0;
                    x_next     = signed'({3'b000, root_next});
                    y_next     = signed'({{3{num[15]}}, num, 8'd0});
                    z_next     = 25'sd0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                if (!y_reg[26])
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_v;
                end
                else
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_v;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == ROT_LAST)
                    state_next = S_ANG;
            end
            S_ANG:
            begin
                ang_next   = ang_sel;
                diff_next  = 25'(filt_reg) - ang_sel;
                acc_next   = 42'sd0;
                ash_next   = alpha;
                cnt_next   = 5'd0;
                state_next = S_FILT;
            end
            S_FILT:
            begin
                acc_next = (acc_reg <<< 1) + addend;
                ash_next = {ash_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == FILT_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                filt_next  = newf[23:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
            filt_reg  <= 24'sd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            filt_reg  <= filt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        ang_reg  <= ang_next;
        diff_reg <= diff_next;
        acc_reg  <= acc_next;
        ash_reg  <= ash_next;
    end

    assign done     = done_reg;
    assign filtered = filt_reg;

endmodule

>>> design/ttsd_duty.sv
// clamp, mirror and linear map of one value onto the duty range, bit-serial divide
module ttsd_duty
    import ttsd_pkg::*;
#(
    parameter int DUTY_MIN = DUTY_MIN_DEF,
    parameter int DUTY_MAX = DUTY_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [24:0] value,
    input  logic signed [24:0] lo,
    input  logic signed [24:0] hi,
    input  logic               mirror,
    output logic               done,
    output logic [13:0]        duty
);

    localparam logic signed [16:0] SPAN  = 17'(DUTY_MAX - DUTY_MIN);
    localparam logic signed [18:0] MIN_S = 19'(DUTY_MIN);
    localparam logic signed [18:0] MAX_S = 19'(DUTY_MAX);
    localparam logic [4:0] DIV_LAST = 5'd16;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic signed [25:0] off_reg, off_next, den_reg, den_next;
    logic signed [42:0] n_reg, n_next;
    logic               neg_reg, neg_next, eq_reg, eq_next;
    logic [25:0]        rem_reg, rem_next, dmag_reg, dmag_next;
    logic [16:0]        qsh_reg, qsh_next;
    logic [13:0]        duty_reg, duty_next;

    logic signed [24:0] vc;
    logic [42:0]        nmag;
    logic [26:0]        remsh, dext;
    logic signed [18:0] q, qd;

    // clamp, magnitude, division step, quotient sign and duty range limit
    always_comb
    begin
        if (value < lo)
            vc = lo;
        else if (value > hi)
            vc = hi;
        else
            vc = value;
        nmag  = n_reg[42] ? 43'(-n_reg) : 43'(n_reg);
        remsh = {rem_reg, qsh_reg[16]};
        dext  = {1'b0, dmag_reg};
        q     = neg_reg ? -(19'(qsh_reg) + 19'(rem_reg != 26'd0)) : 19'(qsh_reg);
        qd    = eq_reg ? MIN_S : q + MIN_S;
        if (qd < MIN_S)
            qd = MIN_S;
        if (qd > MAX_S)
            qd = MAX_S;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        off_next   = off_reg;
        den_next   = den_reg;
        n_next     = n_reg;
        neg_next   = neg_reg;
        eq_next    = eq_reg;
        rem_next   = rem_reg;
        dmag_next  = dmag_reg;
        qsh_next   = qsh_reg;
        duty_next  = duty_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    off_next   = mirror ? 26'(hi) - 26'(vc) : 26'(vc) - 26'(lo);
                    den_next   = 26'(hi) - 26'(lo);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                n_next     = 43'(off_reg) * 43'(SPAN);
                state_next = S_PREP;
            end
            S_PREP:
            begin
                neg_next   = n_reg[42] ^ den_reg[25];
                eq_next    = (den_reg == 26'sd0);
                dmag_next  = den_reg[25] ? 26'(-den_reg) : 26'(den_reg);
                rem_next   = nmag[42:17];
                qsh_next   = nmag[16:0];
                cnt_next   = 5'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (remsh >= dext)
                begin
                    rem_next = 26'(remsh - dext);
                    qsh_next = {qsh_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = remsh[25:0];
                    qsh_next = {qsh_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                duty_next  = qd[13:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        den_reg  <= den_next;
        n_reg    <= n_next;
        neg_reg  <= neg_next;
        eq_reg   <= eq_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        qsh_reg  <= qsh_next;
        duty_reg <= duty_next;
    end

    assign done = done_reg;
    assign duty = duty_reg;

endmodule

>>> test/tb_tilt_to_servo_duty_core.sv
// self-checking testbench for the tilt to servo duty core
`timescale 1ns / 1ps

module tb_tilt_to_servo_duty_core;
    import ttsd_pkg::*;

    localparam int DMIN = 1638;
    localparam int DMAX = 8192;
    localparam int STEPS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [13:0] duty_h;
        logic [13:0] duty_v;
        logic [13:0] duty_e;
    } duty_set_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // accel_x, accel_y, accel_z, pot_sample, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // duty_shoulder_h, duty_shoulder_v, duty_elbow, pad

    tilt_to_servo_duty_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor copy of registers and filter state
    longint alpha_r, hmin_r, hmax_r, vmin_r, vmax_r, plo_r, phi_r, inv_r;
    longint pitch_st, roll_st;

    logic [63:0] pending_items[$];
    duty_set_t   expected_duties[$];
    int          error_count;
    int          items_sent;
    int          results_seen;
    int          idle_cycles;
    bit          sender_pause;
    bit          receiver_random;
    bit          hold_receiver;
    bit          hold_done;
    int          hold_count;
    bit          in_fire;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sext16(longint v);
        sext16 = (v & 16'h8000) ? (v & 16'hFFFF) - 65536 : (v & 16'hFFFF);
    endfunction

    function automatic longint shr_floor(longint v, int s);
        shr_floor = v >>> s;
    endfunction

    function automatic longint int_root(longint n);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sh4000000000000000;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        int_root = res;
    endfunction

    // angle of a against the root of b and c, 1/65536 degree
    function automatic longint tilt_angle(longint a, longint b, longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = int_root((b * b + c * c) << 16);
        y = a * 256;
        z = 0;
        if (x == 0)
            return (y == 0) ? 0 : ((y > 0) ? longint'(DEG90) : -longint'(DEG90));
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + longint'(atan_q16(i[4:0]));
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - longint'(atan_q16(i[4:0]));
            end
        end
        tilt_angle = z;
    endfunction

    function automatic longint smooth_angle(longint old, longint ang);
        smooth_angle = shr_floor(alpha_r * old + (65536 - alpha_r) * ang + 32768, 16);
    endfunction

    function automatic longint div_floor(longint n, longint d);
        if (d < 0)
        begin
            n = -n; d = -d;
        end
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic logic [13:0] map_duty(longint v, longint lo, longint hi, bit mir);
        longint q;
        if (v < lo) v = lo;
        else if (v > hi) v = hi;
        if (mir) v = lo + hi - v;
        if (hi == lo)
            q = DMIN;
        else
            q = div_floor((v - lo) * (DMAX - DMIN), hi - lo) + DMIN;
        if (q < DMIN) q = DMIN;
        if (q > DMAX) q = DMAX;
        map_duty = q[13:0];
    endfunction

    // advance filter state and give the duties for one item
    function automatic duty_set_t predict_duties(logic [63:0] item);
        longint ax;
        longint ay;
        longint az;
        longint pitch;
        longint roll;
        duty_set_t d;
        ax = sext16(item[15:0]);
        ay = sext16(item[31:16]);
        az = sext16(item[47:32]);
        pitch = tilt_angle(ax, ay, az);
        roll = tilt_angle(ay, ax, az);
        pitch_st = smooth_angle(pitch_st, pitch);
        roll_st = smooth_angle(roll_st, roll);
        d.duty_h = map_duty(roll_st, hmin_r * 256, hmax_r * 256, inv_r[0]);
        d.duty_v = map_duty(pitch_st, vmin_r * 256, vmax_r * 256, inv_r[1]);
        d.duty_e = map_duty(longint'(item[59:48]), plo_r, phi_r, inv_r[2]);
        predict_duties = d;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // register write through the config port, mirrored into the predictor
    task automatic write_reg(logic [2:0] idx, longint value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value[31:0];
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ALPHA:  alpha_r = value & 16'hFFFF;
            REG_H_MIN:  hmin_r = sext16(value);
            REG_H_MAX:  hmax_r = sext16(value);
            REG_V_MIN:  vmin_r = sext16(value);
            REG_V_MAX:  vmax_r = sext16(value);
            REG_POT_LO: plo_r = value & 12'hFFF;
            REG_POT_HI: phi_r = value & 12'hFFF;
            default:    inv_r = value & 3'h7;
        endcase
    endtask

    // wait until all items have gone through and all results are back
    task automatic drain;
        while (pending_items.size() != 0 || s_tvalid || expected_duties.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [63:0] make_item(int x, int y, int z, int p);
        make_item = {4'h0, p[11:0], z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic logic [63:0] random_item();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            // gentle tilt with gravity mostly on one axis
            return make_item($urandom_range(0, 16000) - 8000, $urandom_range(0, 16000) - 8000,
                             $urandom_range(0, 16384) + 8000, $urandom_range(0, 4095));
        if (mode < 8)
            return make_item($urandom, $urandom, $urandom, $urandom);
        return make_item($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                         $urandom_range(0, 2) - 1, $urandom_range(0, 1) * 4095);
    endfunction

    // driver, moves on once the offered item was taken at the last rising edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (pending_items.size() != 0 && !sender_pause &&
                (!receiver_random || $urandom_range(0, 99) >= 22))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_items.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver ready, with one long hold
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_count <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_receiver && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == 600)
                hold_done <= 1'b1;
        end
        else
            m_tready <= !receiver_random || ($urandom_range(0, 99) >= 22);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_duties.push_back(predict_duties(s_tdata));
                items_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                duty_set_t got;
                duty_set_t want;
                got = {m_tdata[13:0], m_tdata[27:14], m_tdata[41:28]};
                if (expected_duties.size() == 0)
                begin
                    $display("unexpected result %0d", results_seen);
                    error_count++;
                end
                else
                begin
                    want = expected_duties.pop_front();
                    if (got.duty_h != want.duty_h)
                        report_mismatch("duty_shoulder_h", got.duty_h, want.duty_h);
                    if (got.duty_v != want.duty_v)
                        report_mismatch("duty_shoulder_v", got.duty_v, want.duty_v);
                    if (got.duty_e != want.duty_e)
                        report_mismatch("duty_elbow", got.duty_e, want.duty_e);
                end
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout with %0d results outstanding", expected_duties.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; items_sent = 0; results_seen = 0; idle_cycles = 0;
        sender_pause = 1'b0; receiver_random = 1'b0; hold_receiver = 1'b0;
        alpha_r = 49152; hmin_r = -15360; hmax_r = 15360; vmin_r = -15360;
        vmax_r = 15360; plo_r = 600; phi_r = 4095; inv_r = 0;
        pitch_st = 0; roll_st = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero vectors, vertical gravity, pot limits
        pending_items.push_back(make_item(0, 0, 0, 0));
        pending_items.push_back(make_item(32767, 0, 0, 4095));
        pending_items.push_back(make_item(-32768, 0, 0, 600));
        pending_items.push_back(make_item(0, 32767, 0, 599));
        pending_items.push_back(make_item(0, -32768, 0, 601));
        pending_items.push_back(make_item(0, 0, 32767, 2048));
        pending_items.push_back(make_item(0, 0, -32768, 1));
        pending_items.push_back(make_item(-32768, -32768, -32768, 4095));
        pending_items.push_back(make_item(32767, 32767, 32767, 0));
        pending_items.push_back(make_item(16384, -16384, 100, 3000));
        drain();

        // no smoothing, reversed and equal limits, all mirrors
        write_reg(REG_ALPHA, 0);
        write_reg(REG_H_MIN, 23040);
        write_reg(REG_H_MAX, -23040);
        write_reg(REG_V_MIN, 5000);
        write_reg(REG_V_MAX, 5000);
        write_reg(REG_POT_LO, 4095);
        write_reg(REG_POT_HI, 0);
        write_reg(REG_INVERT, 7);
        pending_items.push_back(make_item(32767, -32768, 0, 0));
        pending_items.push_back(make_item(-32768, 32767, 0, 4095));
        pending_items.push_back(make_item(0, 0, 0, 2000));
        pending_items.push_back(make_item(1000, 1000, 16000, 1234));
        pending_items.push_back(make_item(-20000, 9000, -5000, 77));
        drain();

        // random phases across several settings
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_ALPHA, (phase == 1) ? 65535 : $urandom_range(0, 65535));
            write_reg(REG_H_MIN, (phase == 2) ? -23040 : $urandom_range(0, 46080) - 23040);
            write_reg(REG_H_MAX, (phase == 2) ? 23040 : $urandom_range(0, 46080) - 23040);
            write_reg(REG_V_MIN, $urandom_range(0, 46080) - 23040);
            write_reg(REG_V_MAX, $urandom_range(0, 46080) - 23040);
            write_reg(REG_POT_LO, (phase == 3) ? 0 : $urandom_range(0, 4095));
            write_reg(REG_POT_HI, (phase == 3) ? 4095 : $urandom_range(0, 4095));
            write_reg(REG_INVERT, phase);
            receiver_random = (phase != 0);
            if (phase == 4)
                hold_receiver = 1'b1;
            for (int k = 0; k < 220; k++)
                pending_items.push_back(random_item());
            // sender stops until everything is back, then resumes
            if (phase == 5)
            begin
                while (pending_items.size() > 110)
                    @(posedge clk);
                sender_pause = 1'b1;
                while (s_tvalid || expected_duties.size() != 0)
                    @(posedge clk);
                sender_pause = 1'b0;
            end
            drain();
        end

        $display("covered %0d items and %0d results over eight register settings,",
                 items_sent, results_seen);
        $display("including reversed, equal and full-range limits with all mirrors");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
design/ttsd_pkg.sv
design/ttsd_tilt.sv
design/ttsd_duty.sv
design/tilt_to_servo_duty_core.sv
test/tb_tilt_to_servo_duty_core.sv
